/* rtl/kmpc_pkg.sv */
// Shared field widths, port layouts and item codes of the k-means clustering unit.
`timescale 1ns / 1ps
package kmpc_pkg;
    localparam int CFG_W        = 9;
    localparam int CFG_RESET    = 200;
    localparam int FRAC_BITS    = 8;
    localparam int ENTRY_W      = 8;
    localparam int POS_FIELD_W  = 20;
    localparam int PIX_FIELD_W  = 12;
    localparam int COUNT_W      = 24;
    localparam int NIDX_W       = 10;
    localparam int S_TUSER_W    = 5;
    localparam int S_TDATA_W    = 72;
    localparam int M_TUSER_W    = 1;
    localparam int M_TDATA_W    = 80;
    localparam int M_PAD_W      = M_TDATA_W - NIDX_W - 2 * POS_FIELD_W - COUNT_W;

    localparam logic [2:0] KIND_LOAD    = 3'd0;
    localparam logic [2:0] KIND_CLUSTER = 3'd1;
    localparam logic [2:0] KIND_DEPLOY  = 3'd2;
    localparam logic [2:0] KIND_END     = 3'd3;
    localparam logic [2:0] KIND_READ    = 3'd4;

    localparam logic [1:0] ALL_GROUPS   = 2'd3;

    localparam logic RES_NEAREST = 1'b0;
    localparam logic RES_READ    = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
endpackage

/* rtl/kmpc_div.sv */
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module kmpc_div #(
    parameter int DW = 44,
    parameter int VW = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW:0]   rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [VW:0]   rem_shift;
    logic          fits;

    assign rem_shift = {rem_reg[VW-1:0], quo_reg[DW-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

/* rtl/kmeans_pixel_clustering_unit.sv */
// Top level: k-means centroid store, nearest-centroid scan and end-of-pass update.
// Cluster and deploy scan one centroid per cycle (N per group, G groups scanned).
// End pass: each entry is read, checked and its sums cleared; an entry with members is also divided.
// Reset clears control state, then a clearing pass over all NUM_GROUPS*MAX_PER_GROUP entries
// zeroes the sums and counts; no transaction is accepted until it ends.
`timescale 1ns / 1ps
module kmeans_pixel_clustering_unit #(
    parameter int MAX_PER_GROUP = 256,
    parameter int NUM_GROUPS    = 3,
    parameter int COORD_BITS    = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [kmpc_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_index, pos_x, pos_y, pixel_row, pixel_col
    input  logic [kmpc_pkg::S_TDATA_W-1:0] s_tdata,
    // kind, group
    input  logic [kmpc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // nearest_index, out_x, out_y, out_count, zero pad
    output logic [kmpc_pkg::M_TDATA_W-1:0] m_tdata,
    // result_kind
    output logic [kmpc_pkg::M_TUSER_W-1:0] m_tuser
);
    import kmpc_pkg::*;

    localparam int POS_W  = COORD_BITS + FRAC_BITS;
    localparam int SUM_W  = COORD_BITS + COUNT_W;
    localparam int DIV_W  = SUM_W + FRAC_BITS;
    localparam int DEPTH  = NUM_GROUPS * MAX_PER_GROUP;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW     = $clog2(MAX_PER_GROUP + 1);
    localparam int GW     = $clog2(DEPTH + 1);
    localparam int GCW    = $clog2(NUM_GROUPS + 1);
    localparam int PXW    = (COORD_BITS > PIX_FIELD_W) ? COORD_BITS : PIX_FIELD_W;
    localparam int PSW    = (POS_W > POS_FIELD_W) ? POS_W : POS_FIELD_W;
    localparam int DXW    = POS_W + 1;
    localparam int DIST_W = 2 * DXW + 1;
    localparam int ACC_W  = 2 * SUM_W + COUNT_W;

    typedef enum logic [11:0] {
        ST_CLEAR    = 12'b0000_0000_0001,
        ST_IDLE     = 12'b0000_0000_0010,
        ST_DECODE   = 12'b0000_0000_0100,
        ST_SCAN     = 12'b0000_0000_1000,
        ST_UPD_RD   = 12'b0000_0001_0000,
        ST_UPD_WR   = 12'b0000_0010_0000,
        ST_READ_OUT = 12'b0000_0100_0000,
        ST_END_RD   = 12'b0000_1000_0000,
        ST_END_CHK  = 12'b0001_0000_0000,
        ST_END_DIV  = 12'b0010_0000_0000,
        ST_END_WR   = 12'b0100_0000_0000,
        ST_RESULT   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [2*POS_W-1:0] cent_mem [DEPTH];
    logic [ACC_W-1:0]   acc_mem  [DEPTH];
    logic [2*POS_W-1:0] cent_rdata_reg;
    logic [ACC_W-1:0]   acc_rdata_reg;
    logic               cent_we, cent_re, acc_we, acc_re;
    logic [AW-1:0]      cent_waddr, cent_raddr, acc_waddr, acc_raddr;
    logic [2*POS_W-1:0] cent_wdata;
    logic [ACC_W-1:0]   acc_wdata;

    logic [CFG_W-1:0]   cfg_reg;
    logic [LW-1:0]      n_eff;

    logic [2:0]            kind_reg;
    logic [1:0]            group_reg;
    logic [ENTRY_W-1:0]    entry_reg;
    logic [POS_W-1:0]      posx_reg, posy_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic [PSW-1:0]        posx_wide, posy_wide;
    logic [PXW-1:0]        px_wide, py_wide;
    logic                  grp_ok, entry_ok;
    logic [AW-1:0]         entry_addr;

    logic [GCW-1:0] g0_reg, g0_next, gend_reg, gend_next, gcur_reg, gcur_next;
    logic [LW-1:0]  icur_reg, icur_next;
    logic [GW-1:0]  glob_reg, glob_next;
    logic           iss_reg, iss_next;
    logic [AW-1:0]  scan_addr;
    logic           v1_reg, v2_reg, v3_reg;
    logic [GW-1:0]  t1_glob, t2_glob, t3_glob;
    logic [AW-1:0]  t1_addr, t2_addr, t3_addr;
    logic signed [DXW-1:0]   dx_reg, dy_reg;
    logic signed [2*DXW-1:0] sqx_reg, sqy_reg;
    logic [DIST_W-1:0]       dist_sum;
    logic                    have_reg, have_next;
    logic [DIST_W-1:0]       best_d_reg;
    logic [GW-1:0]           best_glob_reg;
    logic [AW-1:0]           best_addr_reg;
    logic                    best_take;

    logic [AW-1:0] eaddr_reg, eaddr_next, elast_reg, elast_next;
    logic [AW-1:0] clr_reg, clr_next;

    logic [SUM_W-1:0]   acc_srow, acc_scol;
    logic [COUNT_W-1:0] acc_cnt;
    logic               div_start, row_busy, col_busy;
    logic [DIV_W-1:0]   row_quo, col_quo;

    logic                   res_kind_reg, res_kind_next;
    logic [NIDX_W-1:0]      res_idx_reg, res_idx_next;
    logic [POS_FIELD_W-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic [COUNT_W-1:0]     res_cnt_reg, res_cnt_next;
    logic [PSW-1:0]         rx_wide, ry_wide;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 out_load;

    assign posx_wide = PSW'(s_tdata[27:8]);
    assign posy_wide = PSW'(s_tdata[47:28]);
    assign px_wide   = PXW'(s_tdata[59:48]);
    assign py_wide   = PXW'(s_tdata[71:60]);

    always_comb begin
        if (cfg_reg == '0) begin
            n_eff = LW'(1);
        end else if (32'(cfg_reg) > MAX_PER_GROUP) begin
            n_eff = LW'(MAX_PER_GROUP);
        end else begin
            n_eff = LW'(cfg_reg);
        end
    end

    assign grp_ok     = 32'(group_reg) < NUM_GROUPS;
    assign entry_ok   = 32'(entry_reg) < MAX_PER_GROUP;
    assign entry_addr = AW'(32'(group_reg) * MAX_PER_GROUP + 32'(entry_reg));
    assign scan_addr  = AW'(32'(gcur_reg) * MAX_PER_GROUP + 32'(icur_reg));

    assign acc_srow = acc_rdata_reg[ACC_W-1 -: SUM_W];
    assign acc_scol = acc_rdata_reg[COUNT_W +: SUM_W];
    assign acc_cnt  = acc_rdata_reg[COUNT_W-1:0];

    assign dist_sum  = DIST_W'($unsigned(sqx_reg)) + DIST_W'($unsigned(sqy_reg));
    assign best_take = v3_reg && (!have_reg || dist_sum < best_d_reg);

    assign rx_wide = PSW'(cent_rdata_reg[2*POS_W-1 -: POS_W]);
    assign ry_wide = PSW'(cent_rdata_reg[POS_W-1:0]);

    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        g0_next       = g0_reg;
        gend_next     = gend_reg;
        gcur_next     = gcur_reg;
        icur_next     = icur_reg;
        glob_next     = glob_reg;
        iss_next      = iss_reg;
        have_next     = have_reg;
        eaddr_next    = eaddr_reg;
        elast_next    = elast_reg;
        clr_next      = clr_reg;
        res_kind_next = res_kind_reg;
        res_idx_next  = res_idx_reg;
        res_x_next    = res_x_reg;
        res_y_next    = res_y_reg;
        res_cnt_next  = res_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        cent_we       = 1'b0;
        cent_waddr    = entry_addr;
        cent_wdata    = {posx_reg, posy_reg};
        cent_re       = 1'b0;
        cent_raddr    = entry_addr;
        acc_we        = 1'b0;
        acc_waddr     = eaddr_reg;
        acc_wdata     = '0;
        acc_re        = 1'b0;
        acc_raddr     = entry_addr;
        div_start     = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                acc_we    = 1'b1;
                acc_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == DEPTH - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                gcur_next  = GCW'(group_reg);
                g0_next    = GCW'(group_reg);
                gend_next  = GCW'(32'(group_reg) + 1);
                icur_next  = '0;
                glob_next  = '0;
                have_next  = 1'b0;
                eaddr_next = AW'(32'(group_reg) * MAX_PER_GROUP);
                elast_next = AW'(32'(group_reg) * MAX_PER_GROUP + MAX_PER_GROUP - 1);
                case (kind_reg)
                    KIND_LOAD: begin
                        cent_we = grp_ok && entry_ok;
                    end
                    KIND_CLUSTER, KIND_DEPLOY: begin
                        if (kind_reg == KIND_DEPLOY && group_reg == ALL_GROUPS) begin
                            gcur_next  = '0;
                            g0_next    = '0;
                            gend_next  = GCW'(NUM_GROUPS);
                            iss_next   = 1'b1;
                            state_next = ST_SCAN;
                        end else if (grp_ok) begin
                            iss_next   = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                    KIND_END: begin
                        if (group_reg == ALL_GROUPS) begin
                            eaddr_next = '0;
                            elast_next = AW'(DEPTH - 1);
                            state_next = ST_END_RD;
                        end else if (grp_ok) begin
                            state_next = ST_END_RD;
                        end
                    end
                    KIND_READ: begin
                        if (grp_ok && entry_ok) begin
                            cent_re    = 1'b1;
                            acc_re     = 1'b1;
                            state_next = ST_READ_OUT;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (iss_reg) begin
                    cent_re    = 1'b1;
                    cent_raddr = scan_addr;
                    glob_next  = glob_reg + 1'b1;
                    if (icur_reg == LW'(n_eff - 1'b1)) begin
                        icur_next = '0;
                        gcur_next = gcur_reg + 1'b1;
                        if (gcur_reg + 1'b1 == gend_reg) begin
                            iss_next = 1'b0;
                        end
                    end else begin
                        icur_next = icur_reg + 1'b1;
                    end
                end
                if (best_take) begin
                    have_next = 1'b1;
                end
                if (!iss_reg && !v1_reg && !v2_reg && !v3_reg) begin
                    res_kind_next = RES_NEAREST;
                    res_idx_next  = NIDX_W'(32'(g0_reg) * 32'(n_eff) + 32'(best_glob_reg));
                    res_x_next    = '0;
                    res_y_next    = '0;
                    res_cnt_next  = '0;
                    state_next    = (kind_reg == KIND_CLUSTER) ? ST_UPD_RD : ST_RESULT;
                end
            end
            ST_UPD_RD: begin
                acc_re     = 1'b1;
                acc_raddr  = best_addr_reg;
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                acc_waddr  = best_addr_reg;
                acc_wdata  = {acc_srow + SUM_W'(px_reg), acc_scol + SUM_W'(py_reg),
                              acc_cnt + 1'b1};
                acc_we     = (acc_cnt != COUNT_MAX);
                state_next = ST_RESULT;
            end
            ST_READ_OUT: begin
                res_kind_next = RES_READ;
                res_idx_next  = NIDX_W'(32'(group_reg) * 32'(n_eff) + 32'(entry_reg));
                res_x_next    = rx_wide[POS_FIELD_W-1:0];
                res_y_next    = ry_wide[POS_FIELD_W-1:0];
                res_cnt_next  = acc_cnt;
                state_next    = ST_RESULT;
            end
            ST_END_RD: begin
                acc_re     = 1'b1;
                acc_raddr  = eaddr_reg;
                state_next = ST_END_CHK;
            end
            ST_END_CHK: begin
                acc_we = 1'b1;
                if (acc_cnt != '0) begin
                    div_start  = 1'b1;
                    state_next = ST_END_DIV;
                end else if (eaddr_reg == elast_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    eaddr_next = eaddr_reg + 1'b1;
                    state_next = ST_END_RD;
                end
            end
            ST_END_DIV: begin
                if (!row_busy && !col_busy) begin
                    state_next = ST_END_WR;
                end
            end
            ST_END_WR: begin
                cent_we    = 1'b1;
                cent_waddr = eaddr_reg;
                cent_wdata = {row_quo[POS_W-1:0], col_quo[POS_W-1:0]};
                if (eaddr_reg == elast_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    eaddr_next = eaddr_reg + 1'b1;
                    state_next = ST_END_RD;
                end
            end
            ST_RESULT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cfg_reg      <= CFG_W'(CFG_RESET);
            clr_reg      <= '0;
            iss_reg      <= 1'b0;
            have_reg     <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            iss_reg      <= iss_next;
            have_reg     <= have_next;
            v1_reg       <= iss_reg && (state_reg == ST_SCAN);
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        g0_reg       <= g0_next;
        gend_reg     <= gend_next;
        gcur_reg     <= gcur_next;
        icur_reg     <= icur_next;
        glob_reg     <= glob_next;
        eaddr_reg    <= eaddr_next;
        elast_reg    <= elast_next;
        res_kind_reg <= res_kind_next;
        res_idx_reg  <= res_idx_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_cnt_reg  <= res_cnt_next;
        if (s_tvalid && s_tready) begin
            kind_reg  <= s_tuser[2:0];
            group_reg <= s_tuser[4:3];
            entry_reg <= s_tdata[7:0];
            posx_reg  <= posx_wide[POS_W-1:0];
            posy_reg  <= posy_wide[POS_W-1:0];
            px_reg    <= px_wide[COORD_BITS-1:0];
            py_reg    <= py_wide[COORD_BITS-1:0];
        end
        t1_glob <= glob_reg;
        t1_addr <= scan_addr;
        t2_glob <= t1_glob;
        t2_addr <= t1_addr;
        t3_glob <= t2_glob;
        t3_addr <= t2_addr;
        dx_reg  <= $signed({1'b0, px_reg, {FRAC_BITS{1'b0}}})
                 - $signed({1'b0, cent_rdata_reg[2*POS_W-1 -: POS_W]});
        dy_reg  <= $signed({1'b0, py_reg, {FRAC_BITS{1'b0}}})
                 - $signed({1'b0, cent_rdata_reg[POS_W-1:0]});
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
        if (best_take) begin
            best_d_reg    <= dist_sum;
            best_glob_reg <= t3_glob;
            best_addr_reg <= t3_addr;
        end
        if (out_load) begin
            m_tuser_reg <= res_kind_reg;
            m_tdata_reg <= {{M_PAD_W{1'b0}}, res_cnt_reg, res_y_reg, res_x_reg, res_idx_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cent_we) begin
            cent_mem[cent_waddr] <= cent_wdata;
        end
        if (cent_re) begin
            cent_rdata_reg <= cent_mem[cent_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        if (acc_re) begin
            acc_rdata_reg <= acc_mem[acc_raddr];
        end
    end

    kmpc_div #(
        .DW(DIV_W),
        .VW(COUNT_W)
    ) u_div_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({acc_srow, {FRAC_BITS{1'b0}}}),
        .divisor  (acc_cnt),
        .busy     (row_busy),
        .quotient (row_quo)
    );

    kmpc_div #(
        .DW(DIV_W),
        .VW(COUNT_W)
    ) u_div_col (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({acc_scol, {FRAC_BITS{1'b0}}}),
        .divisor  (acc_cnt),
        .busy     (col_busy),
        .quotient (col_quo)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
endmodule

/* rtl/kmpc_checker.sv */
// Port-level checker for the k-means clustering unit and its bind.
`timescale 1ns / 1ps
module kmpc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [kmpc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [kmpc_pkg::M_TUSER_W-1:0] m_tuser
);
    import kmpc_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("ports active after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("transaction accepted while busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_nearest_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == RES_NEAREST) |-> (m_tdata[M_TDATA_W-1:NIDX_W] == '0))
        else $error("nearest answer carries centroid data");
endmodule

bind kmeans_pixel_clustering_unit kmpc_checker u_kmpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
